// ===== rtl/bcm_pkg.sv =====
package bcm_pkg;

    // Field widths
    localparam int COORD_W   = 12;
    localparam int EDGE_W    = 13;
    localparam int BOX_W     = 4 * COORD_W;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int SUM_W     = SQ_W + 1;
    localparam int EPS_W     = 13;
    localparam int EPS2_W    = 2 * EPS_W;
    localparam int MINP_W    = 7;
    localparam int ID_OUT_W  = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 13;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EPS_DISTANCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_POINTS   = 1'd1;

    // Register reset values
    localparam logic [EPS_W-1:0]  EPS_RESET  = 13'd300;
    localparam logic [MINP_W-1:0] MINP_RESET = 7'd2;

    // Default store depth
    localparam int MAX_BOXES_DEF = 32;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SEEK,
        ST_DIST,
        ST_DDRAIN,
        ST_LABEL,
        ST_UID,
        ST_USCAN,
        ST_UDRAIN,
        ST_UEND,
        ST_EMIT,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic load_box;
        logic i_clear;
        logic i_inc;
        logic pass_start;
        logic dist_issue;
        logic union_issue;
        logic label_apply;
        logic id_clear;
        logic id_inc;
        logic pend_load;
        logic out_load;
        logic out_use_pend;
        logic out_last;
        logic set_clear;
    } cmd_t;

    typedef struct packed {
        logic i_at_end;
        logic i_labeled;
        logic j_at_end;
        logic pipe_empty;
        logic cnt_ok;
        logic id_at_end;
        logic acc_any;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/bcm_ctrl.sv =====
module bcm_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_last_box,
    output logic             s_ready,
    input  bcm_pkg::status_t status,
    output bcm_pkg::cmd_t    cmd
);
    import bcm_pkg::*;

    state_t state_reg, state_next;
    logic   have_pend_reg, have_pend_next;

    // State and pending-result flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            have_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            have_pend_reg <= have_pend_next;
        end
    end

    // Sequence the load, distance, labeling and union passes and the result output
    always_comb begin
        state_next     = state_reg;
        have_pend_next = have_pend_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready      = 1'b1;
                cmd.load_box = s_valid;
                if (s_valid && s_last_box) begin
                    cmd.i_clear  = 1'b1;
                    cmd.id_clear = 1'b1;
                    state_next   = ST_SEEK;
                end
            end
            ST_SEEK: begin
                if (status.i_at_end) begin
                    state_next = ST_UID;
                end else if (status.i_labeled) begin
                    cmd.i_inc = 1'b1;
                end else begin
                    cmd.pass_start = 1'b1;
                    state_next     = ST_DIST;
                end
            end
            ST_DIST: begin
                if (status.j_at_end) begin
                    state_next = ST_DDRAIN;
                end else begin
                    cmd.dist_issue = 1'b1;
                end
            end
            ST_DDRAIN: begin
                if (status.pipe_empty) begin
                    state_next = ST_LABEL;
                end
            end
            ST_LABEL: begin
                cmd.label_apply = status.cnt_ok;
                cmd.i_inc       = 1'b1;
                state_next      = ST_SEEK;
            end
            ST_UID: begin
                if (status.id_at_end) begin
                    state_next = ST_FINAL;
                end else begin
                    cmd.pass_start = 1'b1;
                    state_next     = ST_USCAN;
                end
            end
            ST_USCAN: begin
                if (status.j_at_end) begin
                    state_next = ST_UDRAIN;
                end else begin
                    cmd.union_issue = 1'b1;
                end
            end
            ST_UDRAIN: begin
                if (status.pipe_empty) begin
                    state_next = ST_UEND;
                end
            end
            ST_UEND: begin
                if (status.acc_any && have_pend_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    if (status.acc_any) begin
                        cmd.pend_load  = 1'b1;
                        have_pend_next = 1'b1;
                    end
                    cmd.id_inc = 1'b1;
                    state_next = ST_UID;
                end
            end
            ST_EMIT: begin
                // Send the held result, then hold the new one
                if (status.out_free) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_use_pend = 1'b1;
                    cmd.pend_load    = 1'b1;
                    cmd.id_inc       = 1'b1;
                    state_next       = ST_UID;
                end
            end
            ST_FINAL: begin
                if (status.out_free) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_use_pend = have_pend_reg;
                    cmd.out_last     = 1'b1;
                    cmd.set_clear    = 1'b1;
                    have_pend_next   = 1'b0;
                    state_next       = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ===== rtl/bcm_dpath.sv =====
module bcm_dpath #(
    parameter int MAX_BOXES = bcm_pkg::MAX_BOXES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [bcm_pkg::CFG_IDX_W-1:0]        cfg_wr_index,
    input  logic [bcm_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    input  logic [bcm_pkg::COORD_W-1:0]          s_center_x,
    input  logic [bcm_pkg::COORD_W-1:0]          s_center_y,
    input  logic [bcm_pkg::COORD_W-1:0]          s_half_width,
    input  logic [bcm_pkg::COORD_W-1:0]          s_half_height,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic [bcm_pkg::ID_OUT_W-1:0]         m_cluster_id,
    output logic signed [bcm_pkg::EDGE_W-1:0]    m_left,
    output logic signed [bcm_pkg::EDGE_W-1:0]    m_top,
    output logic [bcm_pkg::EDGE_W-1:0]           m_right,
    output logic [bcm_pkg::EDGE_W-1:0]           m_bottom,
    output logic                                 m_empty_res,
    output logic                                 m_last_result,
    input  bcm_pkg::cmd_t                        cmd,
    output bcm_pkg::status_t                     status
);
    import bcm_pkg::*;

    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int LBL_W = IDX_W;
    localparam int CMP_W = (CNT_W > MINP_W) ? CNT_W : MINP_W;

    // Box store: one write port, two registered read ports
    logic [BOX_W-1:0] box_mem [MAX_BOXES];
    logic [BOX_W-1:0] rd_a_reg, rd_b_reg;

    // Configuration
    logic [EPS_W-1:0]  eps_reg;
    logic [MINP_W-1:0] minp_reg;
    logic [EPS2_W-1:0] eps_sq_reg;

    // Counters and labels
    logic [CNT_W-1:0]     count_reg, next_reg, i_reg, j_reg, id_reg, cnt_reg;
    logic [MAX_BOXES-1:0] label_valid_reg, near_reg;
    logic [LBL_W-1:0]     label_reg [MAX_BOXES];

    // Distance pipeline
    logic                     d1_vld_reg, d2_vld_reg, d3_vld_reg;
    logic [IDX_W-1:0]         d1_idx_reg, d2_idx_reg, d3_idx_reg;
    logic signed [EDGE_W-1:0] d2_dx_reg, d2_dy_reg;
    logic [SQ_W-1:0]          d3_sqx_reg, d3_sqy_reg;
    logic signed [2*EDGE_W-1:0] prod_x, prod_y;
    logic [SUM_W-1:0]         dist_sum;
    logic                     dist_hit;

    // Union pipeline and accumulators
    logic                     u1_vld_reg, u1_mem_reg, u2_vld_reg, u2_mem_reg;
    logic signed [EDGE_W-1:0] u2_l_reg, u2_t_reg, acc_l_reg, acc_t_reg;
    logic [EDGE_W-1:0]        u2_r_reg, u2_b_reg, acc_r_reg, acc_b_reg;
    logic                     acc_any_reg;

    // Held result
    logic [LBL_W-1:0]         pend_id_reg;
    logic signed [EDGE_W-1:0] pend_l_reg, pend_t_reg;
    logic [EDGE_W-1:0]        pend_r_reg, pend_b_reg;

    // Output register
    logic                     m_valid_reg, m_empty_reg, m_last_reg;
    logic [ID_OUT_W-1:0]      m_id_reg;
    logic signed [EDGE_W-1:0] m_l_reg, m_t_reg;
    logic [EDGE_W-1:0]        m_r_reg, m_b_reg;

    logic [IDX_W-1:0] i_idx, j_idx, wr_idx;
    logic             store_wr, member;
    logic [COORD_W-1:0] a_cx, a_cy, b_cx, b_cy, b_hw, b_hh;

    assign i_idx    = i_reg[IDX_W-1:0];
    assign j_idx    = j_reg[IDX_W-1:0];
    assign wr_idx   = count_reg[IDX_W-1:0];
    assign store_wr = cmd.load_box && (count_reg < CNT_W'(MAX_BOXES));
    assign member   = label_valid_reg[j_idx] && (label_reg[j_idx] == id_reg[LBL_W-1:0]);

    assign a_cx = rd_a_reg[4*COORD_W-1:3*COORD_W];
    assign a_cy = rd_a_reg[3*COORD_W-1:2*COORD_W];
    assign b_cx = rd_b_reg[4*COORD_W-1:3*COORD_W];
    assign b_cy = rd_b_reg[3*COORD_W-1:2*COORD_W];
    assign b_hw = rd_b_reg[2*COORD_W-1:COORD_W];
    assign b_hh = rd_b_reg[COORD_W-1:0];

    assign prod_x   = d2_dx_reg * d2_dx_reg;
    assign prod_y   = d2_dy_reg * d2_dy_reg;
    assign dist_sum = SUM_W'(d3_sqx_reg) + SUM_W'(d3_sqy_reg);
    assign dist_hit = EPS2_W'(dist_sum) <= eps_sq_reg;

    // Store write and reads
    always_ff @(posedge aclk) begin
        if (store_wr) begin
            box_mem[wr_idx] <= {s_center_x, s_center_y, s_half_width, s_half_height};
        end
        rd_a_reg <= box_mem[i_idx];
        rd_b_reg <= box_mem[j_idx];
    end

    // Control state: configuration, counters, labels valid, pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg         <= EPS_RESET;
            minp_reg        <= MINP_RESET;
            count_reg       <= '0;
            next_reg        <= '0;
            i_reg           <= '0;
            j_reg           <= '0;
            id_reg          <= '0;
            cnt_reg         <= '0;
            label_valid_reg <= '0;
            d1_vld_reg      <= 1'b0;
            d2_vld_reg      <= 1'b0;
            d3_vld_reg      <= 1'b0;
            u1_vld_reg      <= 1'b0;
            u2_vld_reg      <= 1'b0;
            acc_any_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en && (cfg_wr_index == CFG_EPS_DISTANCE)) begin
                eps_reg <= cfg_wr_data[EPS_W-1:0];
            end
            if (cfg_wr_en && (cfg_wr_index == CFG_MIN_POINTS)) begin
                minp_reg <= cfg_wr_data[MINP_W-1:0];
            end

            if (store_wr) begin
                count_reg <= count_reg + 1'b1;
            end

            if (cmd.i_clear) begin
                i_reg <= '0;
            end else if (cmd.i_inc) begin
                i_reg <= i_reg + 1'b1;
            end

            if (cmd.pass_start) begin
                j_reg <= '0;
            end else if (cmd.dist_issue || cmd.union_issue) begin
                j_reg <= j_reg + 1'b1;
            end

            if (cmd.id_clear) begin
                id_reg <= '0;
            end else if (cmd.id_inc) begin
                id_reg <= id_reg + 1'b1;
            end

            // Count neighbors at the end of the distance pipeline
            if (cmd.pass_start) begin
                cnt_reg <= '0;
            end else if (d3_vld_reg && dist_hit) begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            // Label every gathered box with the next cluster id
            if (cmd.label_apply) begin
                for (int k = 0; k < MAX_BOXES; k++) begin
                    if (near_reg[k]) begin
                        label_valid_reg[k] <= 1'b1;
                    end
                end
                next_reg <= next_reg + 1'b1;
            end

            d1_vld_reg <= cmd.dist_issue;
            d2_vld_reg <= d1_vld_reg;
            d3_vld_reg <= d2_vld_reg;
            u1_vld_reg <= cmd.union_issue;
            u2_vld_reg <= u1_vld_reg;

            if (cmd.pass_start) begin
                acc_any_reg <= 1'b0;
            end else if (u2_vld_reg && u2_mem_reg) begin
                acc_any_reg <= 1'b1;
            end

            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // Drop the finished set
            if (cmd.set_clear) begin
                label_valid_reg <= '0;
                count_reg       <= '0;
                next_reg        <= '0;
            end
        end
    end

    // Payload: labels, neighbor flags, pipeline data, union and output fields
    always_ff @(posedge aclk) begin
        if (cmd.label_apply) begin
            for (int k = 0; k < MAX_BOXES; k++) begin
                if (near_reg[k]) begin
                    label_reg[k] <= next_reg[LBL_W-1:0];
                end
            end
        end

        eps_sq_reg <= EPS2_W'(eps_reg) * EPS2_W'(eps_reg);

        if (cmd.pass_start) begin
            near_reg <= '0;
        end else if (d3_vld_reg) begin
            near_reg[d3_idx_reg] <= dist_hit;
        end

        d1_idx_reg <= j_idx;
        d2_idx_reg <= d1_idx_reg;
        d3_idx_reg <= d2_idx_reg;
        d2_dx_reg  <= $signed({1'b0, a_cx}) - $signed({1'b0, b_cx});
        d2_dy_reg  <= $signed({1'b0, a_cy}) - $signed({1'b0, b_cy});
        d3_sqx_reg <= prod_x[SQ_W-1:0];
        d3_sqy_reg <= prod_y[SQ_W-1:0];

        // Edges of the box just read
        u1_mem_reg <= member;
        u2_mem_reg <= u1_mem_reg;
        u2_l_reg   <= $signed({1'b0, b_cx}) - $signed({1'b0, b_hw});
        u2_t_reg   <= $signed({1'b0, b_cy}) - $signed({1'b0, b_hh});
        u2_r_reg   <= {1'b0, b_cx} + {1'b0, b_hw};
        u2_b_reg   <= {1'b0, b_cy} + {1'b0, b_hh};

        // Grow the union rectangle
        if (u2_vld_reg && u2_mem_reg) begin
            if (!acc_any_reg || (u2_l_reg < acc_l_reg)) acc_l_reg <= u2_l_reg;
            if (!acc_any_reg || (u2_t_reg < acc_t_reg)) acc_t_reg <= u2_t_reg;
            if (!acc_any_reg || (u2_r_reg > acc_r_reg)) acc_r_reg <= u2_r_reg;
            if (!acc_any_reg || (u2_b_reg > acc_b_reg)) acc_b_reg <= u2_b_reg;
        end

        if (cmd.pend_load) begin
            pend_id_reg <= id_reg[LBL_W-1:0];
            pend_l_reg  <= acc_l_reg;
            pend_t_reg  <= acc_t_reg;
            pend_r_reg  <= acc_r_reg;
            pend_b_reg  <= acc_b_reg;
        end

        if (cmd.out_load) begin
            m_last_reg <= cmd.out_last;
            if (cmd.out_use_pend) begin
                m_id_reg    <= ID_OUT_W'(pend_id_reg);
                m_l_reg     <= pend_l_reg;
                m_t_reg     <= pend_t_reg;
                m_r_reg     <= pend_r_reg;
                m_b_reg     <= pend_b_reg;
                m_empty_reg <= 1'b0;
            end else begin
                m_id_reg    <= '0;
                m_l_reg     <= '0;
                m_t_reg     <= '0;
                m_r_reg     <= '0;
                m_b_reg     <= '0;
                m_empty_reg <= 1'b1;
            end
        end
    end

    // Status to the controller
    always_comb begin
        status.i_at_end   = (i_reg == count_reg);
        status.i_labeled  = label_valid_reg[i_idx];
        status.j_at_end   = (j_reg == count_reg);
        status.pipe_empty = !(d1_vld_reg || d2_vld_reg || d3_vld_reg ||
                              u1_vld_reg || u2_vld_reg);
        status.cnt_ok     = CMP_W'(cnt_reg) >= CMP_W'(minp_reg);
        status.id_at_end  = (id_reg == next_reg);
        status.acc_any    = acc_any_reg;
        status.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid       = m_valid_reg;
    assign m_cluster_id  = m_id_reg;
    assign m_left        = m_l_reg;
    assign m_top         = m_t_reg;
    assign m_right       = m_r_reg;
    assign m_bottom      = m_b_reg;
    assign m_empty_res   = m_empty_reg;
    assign m_last_result = m_last_reg;

endmodule

// ===== rtl/box_cluster_merge_unit.sv =====
// Boxes load one request per cycle while in the load state, and a box that does not
// close the set gives no result. After the closing box, each unlabeled seed runs a
// distance pass and each cluster id a union scan over all N stored boxes, each pass
// reading the stored boxes one at a time through one store read port.
// Results leave at most one per cycle through an output register.
// Synchronous active-low reset clears labels, counts and sets eps 300, min points 2.
module box_cluster_merge_unit #(
    parameter int MAX_BOXES = bcm_pkg::MAX_BOXES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bcm_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [bcm_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bcm_pkg::COORD_W-1:0]       s_center_x,
    input  logic [bcm_pkg::COORD_W-1:0]       s_center_y,
    input  logic [bcm_pkg::COORD_W-1:0]       s_half_width,
    input  logic [bcm_pkg::COORD_W-1:0]       s_half_height,
    input  logic                              s_last_box,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bcm_pkg::ID_OUT_W-1:0]      m_cluster_id,
    output logic signed [bcm_pkg::EDGE_W-1:0] m_left,
    output logic signed [bcm_pkg::EDGE_W-1:0] m_top,
    output logic [bcm_pkg::EDGE_W-1:0]        m_right,
    output logic [bcm_pkg::EDGE_W-1:0]        m_bottom,
    output logic                              m_empty_res,
    output logic                              m_last_result
);
    import bcm_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer
    bcm_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_last_box (s_last_box),
        .s_ready    (s_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Store, distance and union datapath
    bcm_dpath #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .s_half_width  (s_half_width),
        .s_half_height (s_half_height),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_cluster_id  (m_cluster_id),
        .m_left        (m_left),
        .m_top         (m_top),
        .m_right       (m_right),
        .m_bottom      (m_bottom),
        .m_empty_res   (m_empty_res),
        .m_last_result (m_last_result),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

// ===== rtl/bcm_checker.sv =====
module bcm_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [bcm_pkg::ID_OUT_W-1:0]      m_cluster_id,
    input logic signed [bcm_pkg::EDGE_W-1:0] m_left,
    input logic signed [bcm_pkg::EDGE_W-1:0] m_top,
    input logic [bcm_pkg::EDGE_W-1:0]        m_right,
    input logic [bcm_pkg::EDGE_W-1:0]        m_bottom,
    input logic                              m_empty_res,
    input logic                              m_last_result
);
    import bcm_pkg::*;

    // No result right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before it was taken");

    // An empty result closes the set and carries zero fields
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_empty_res |-> m_last_result && (m_cluster_id == '0) &&
        (m_left == '0) && (m_top == '0) && (m_right == '0) && (m_bottom == '0))
        else $error("malformed empty result");

    // A union rectangle never has its left edge past its right edge or its top past its bottom
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_empty_res |->
        ($signed({m_left[EDGE_W-1], m_left}) <= $signed({1'b0, m_right})) &&
        ($signed({m_top[EDGE_W-1], m_top}) <= $signed({1'b0, m_bottom})))
        else $error("union rectangle inverted");

endmodule

bind box_cluster_merge_unit bcm_checker u_bcm_checker (.*);
